// ----- rtl/tmsn_pkg.sv -----
// Package for the trimmed-mean sensor normalizer: sizes, codes, states and divider types.
package tmsn_pkg;

   localparam int WINDOW     = 5;
   localparam int NCH        = 4;
   localparam int SAMPLE_W   = 12;
   localparam int LEVEL_W    = 15;
   localparam int MODE_W     = 3;
   localparam int ROUND_W    = $clog2(WINDOW);
   localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW);
   localparam int TRIM_W     = SAMPLE_W + 1;
   localparam int CH_W       = $clog2(NCH);
   localparam int DVD_W      = SAMPLE_W + LEVEL_W;
   localparam int DIV_CNT_W  = $clog2(DVD_W + 1);
   localparam int CSR_IDX_W  = $clog2(2 * NCH);
   localparam int CSR_AW     = CSR_IDX_W + 2;
   localparam int CSR_DW     = 32;

   // trimmed-mean divide by WINDOW-2 as a reciprocal multiply, exact for any SUM_W-bit sum
   localparam int TRIM_DIV   = WINDOW - 2;
   localparam int TRIM_SHIFT = 18;
   localparam int RECIP_W    = TRIM_SHIFT + 1;
   localparam int MP_W       = SUM_W + RECIP_W;

   localparam logic [ROUND_W-1:0]  ROUND_LAST   = ROUND_W'(WINDOW - 1);
   localparam logic [CH_W-1:0]     CH_LAST      = CH_W'(NCH - 1);
   localparam logic [RECIP_W-1:0]  TRIM_RECIP   =
      RECIP_W'((2 ** TRIM_SHIFT + TRIM_DIV - 1) / TRIM_DIV);
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = {SAMPLE_W{1'b1}};
   localparam logic [LEVEL_W-1:0]  FULL_LEVEL   = LEVEL_W'(32000);
   localparam logic [LEVEL_W-1:0]  LEVEL_HIGH   = LEVEL_W'(140 * 64);
   localparam logic [LEVEL_W-1:0]  LEVEL_LOW    = LEVEL_W'(40 * 64);
   localparam logic [SAMPLE_W-1:0] MAX_RESET    = SAMPLE_W'(3800);
   localparam logic [SAMPLE_W-1:0] MIN_RESET    = '0;

   localparam logic [MODE_W-1:0] STEER_HIGH_LOW   = MODE_W'(1);
   localparam logic [MODE_W-1:0] STEER_LOW_HIGH   = MODE_W'(2);
   localparam logic [MODE_W-1:0] STEER_COPY_LOWER = MODE_W'(3);
   localparam logic [MODE_W-1:0] STEER_LEFT_RIGHT = MODE_W'(4);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MEAN_GO,
      ST_MEAN_WAIT,
      ST_SCALE,
      ST_LEVEL_GO,
      ST_LEVEL_WAIT,
      ST_NEXT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                start;
      logic [DVD_W-1:0]    dividend;
      logic [SAMPLE_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ----- rtl/tmsn_req_if.sv -----
// Input channel: one round of four coil samples plus steering mode.
interface tmsn_req_if;
   import tmsn_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample_lower_left;
   logic [SAMPLE_W-1:0] sample_lower_right;
   logic [SAMPLE_W-1:0] sample_upper_left;
   logic [SAMPLE_W-1:0] sample_upper_right;
   logic [MODE_W-1:0]   steer_mode;

   modport source (output valid, sample_lower_left, sample_lower_right, sample_upper_left,
                   sample_upper_right, steer_mode, input ready);
   modport sink   (input valid, sample_lower_left, sample_lower_right, sample_upper_left,
                   sample_upper_right, steer_mode, output ready);
endinterface

// ----- rtl/tmsn_rsp_if.sv -----
// Result channel: normalized levels and trimmed means of four channels.
interface tmsn_rsp_if;
   import tmsn_pkg::*;
   logic                valid;
   logic                ready;
   logic [LEVEL_W-1:0]  level_lower_left;
   logic [LEVEL_W-1:0]  level_lower_right;
   logic [LEVEL_W-1:0]  level_upper_left;
   logic [LEVEL_W-1:0]  level_upper_right;
   logic [SAMPLE_W-1:0] filtered_lower_left;
   logic [SAMPLE_W-1:0] filtered_lower_right;
   logic [SAMPLE_W-1:0] filtered_upper_left;
   logic [SAMPLE_W-1:0] filtered_upper_right;

   modport source (output valid, level_lower_left, level_lower_right, level_upper_left,
                   level_upper_right, filtered_lower_left, filtered_lower_right,
                   filtered_upper_left, filtered_upper_right, input ready);
   modport sink   (input valid, level_lower_left, level_lower_right, level_upper_left,
                   level_upper_right, filtered_lower_left, filtered_lower_right,
                   filtered_upper_left, filtered_upper_right, output ready);
endinterface

// ----- rtl/tmsn_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
module tmsn_div
   import tmsn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DVD_W - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0]     quo_ff, quo_in;
   logic [SAMPLE_W-1:0]  rem_ff, rem_in;
   logic [SAMPLE_W-1:0]  dsr_ff, dsr_in;
   logic [SAMPLE_W:0]    rem_sh;
   logic [SAMPLE_W:0]    rem_sub;
   logic                 fits;

   assign rem_sh  = {rem_ff, quo_ff[DVD_W-1]};
   assign fits    = rem_sh >= {1'b0, dsr_ff};
   assign rem_sub = rem_sh - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (div_req.start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVD_W-2:0], fits};
         rem_in = fits ? rem_sub[SAMPLE_W-1:0] : rem_sh[SAMPLE_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("divider done without a running division");

endmodule

// ----- rtl/trimmed_mean_sensor_normalizer_top.sv -----
// Top level of the trimmed-mean sensor normalizer with its register port.
// Every accepted beat adds one round of four samples to the per-channel sum, peak and floor
// registers; rounds that do not close the window give no result and the block stays ready.
// The round that closes the window starts a sequencer that walks the four channels in turn:
// the trimmed mean comes from a reciprocal multiply in ST_MEAN_GO and is checked against the
// calibrated span in ST_MEAN_WAIT; only a mean strictly inside the span goes on through the
// multiplier register in ST_SCALE and the shared 27-step restoring divider for its level. A
// channel whose level clamps or whose span is degenerate goes straight on to ST_NEXT; after
// the last channel ST_FINISH loads the result register; req_ch.ready is low until then.
// The result beat then sits in an output register; the next window's rounds are taken while
// it waits, and a further closing round holds in the last step until that register frees.
module trimmed_mean_sensor_normalizer_top
   import tmsn_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   tmsn_req_if.sink          req_ch,
   tmsn_rsp_if.source        rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   state_type           state_ff, state_in;
   logic [CH_W-1:0]     ch_ff, ch_in;
   logic [ROUND_W-1:0]  round_ff, round_in;
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [SUM_W-1:0]    sum_ff[NCH], sum_in[NCH];
   logic [SAMPLE_W-1:0] peak_ff[NCH], peak_in[NCH];
   logic [SAMPLE_W-1:0] floor_ff[NCH], floor_in[NCH];
   logic [SAMPLE_W-1:0] mean_ff[NCH], mean_in[NCH];
   logic [LEVEL_W-1:0]  level_ff[NCH], level_in[NCH];
   logic [DVD_W-1:0]    prod_ff, prod_in;
   logic [LEVEL_W-1:0]  lvl_out_ff[NCH], lvl_out_in[NCH];
   logic [SAMPLE_W-1:0] filt_out_ff[NCH], filt_out_in[NCH];
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] max_ff[NCH];
   logic [SAMPLE_W-1:0] min_ff[NCH];

   logic [SAMPLE_W-1:0] samp[NCH];
   logic [LEVEL_W-1:0]  lvl_ovr[NCH];
   logic [SAMPLE_W-1:0] hi, lo;
   logic [TRIM_W-1:0]   trim;
   logic [SUM_W-1:0]    diff;
   logic [MP_W-1:0]     mean_prod;
   logic [SAMPLE_W-1:0] mean_new;
   logic [SAMPLE_W-1:0] mean_lo;
   logic [DVD_W-1:0]    scale_prod;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic                csr_wr;
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   tmsn_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // register port
   assign pready  = 1'b1;
   assign csr_idx = paddr[CSR_AW-1:2];
   assign csr_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NCH; c++) begin
            max_ff[c] <= MAX_RESET;
            min_ff[c] <= MIN_RESET;
         end
      end else if (csr_wr) begin
         if (csr_idx[CSR_IDX_W-1]) begin
            min_ff[csr_idx[CH_W-1:0]] <= pwdata[SAMPLE_W-1:0];
         end else begin
            max_ff[csr_idx[CH_W-1:0]] <= pwdata[SAMPLE_W-1:0];
         end
      end
   end

   always_comb begin
      if (csr_idx[CSR_IDX_W-1]) begin
         prdata = CSR_DW'(min_ff[csr_idx[CH_W-1:0]]);
      end else begin
         prdata = CSR_DW'(max_ff[csr_idx[CH_W-1:0]]);
      end
   end

   // datapath around the shared divider
   assign samp[0] = req_ch.sample_lower_left;
   assign samp[1] = req_ch.sample_lower_right;
   assign samp[2] = req_ch.sample_upper_left;
   assign samp[3] = req_ch.sample_upper_right;

   assign hi         = max_ff[ch_ff];
   assign lo         = min_ff[ch_ff];
   assign trim       = {1'b0, peak_ff[ch_ff]} + {1'b0, floor_ff[ch_ff]};
   assign diff       = (sum_ff[ch_ff] > SUM_W'(trim)) ? sum_ff[ch_ff] - SUM_W'(trim) : '0;
   assign mean_prod  = diff * TRIM_RECIP;
   assign mean_new   = (|mean_prod[MP_W-1:TRIM_SHIFT+SAMPLE_W]) ? SAMPLE_MAX
                                                               : mean_prod[TRIM_SHIFT +: SAMPLE_W];
   assign mean_lo    = mean_ff[ch_ff] - lo;
   assign scale_prod = mean_lo * FULL_LEVEL;

   always_comb begin
      for (int c = 0; c < NCH; c++) begin
         lvl_ovr[c] = level_ff[c];
      end
      unique case (mode_ff)
         STEER_HIGH_LOW: begin
            lvl_ovr[2] = LEVEL_HIGH;
            lvl_ovr[3] = LEVEL_LOW;
         end
         STEER_LOW_HIGH: begin
            lvl_ovr[2] = LEVEL_LOW;
            lvl_ovr[3] = LEVEL_HIGH;
         end
         STEER_COPY_LOWER: begin
            lvl_ovr[2] = level_ff[0];
            lvl_ovr[3] = level_ff[1];
         end
         STEER_LEFT_RIGHT: begin
            lvl_ovr[2] = level_ff[3];
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      round_in     = round_ff;
      mode_in      = mode_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      for (int c = 0; c < NCH; c++) begin
         sum_in[c]      = sum_ff[c];
         peak_in[c]     = peak_ff[c];
         floor_in[c]    = floor_ff[c];
         mean_in[c]     = mean_ff[c];
         level_in[c]    = level_ff[c];
         lvl_out_in[c]  = lvl_out_ff[c];
         filt_out_in[c] = filt_out_ff[c];
      end
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               for (int c = 0; c < NCH; c++) begin
                  sum_in[c]   = sum_ff[c] + SUM_W'(samp[c]);
                  peak_in[c]  = (samp[c] > peak_ff[c]) ? samp[c] : peak_ff[c];
                  floor_in[c] = (samp[c] < floor_ff[c]) ? samp[c] : floor_ff[c];
               end
               mode_in = req_ch.steer_mode;
               if (round_ff < ROUND_LAST) begin
                  round_in = round_ff + 1'b1;
               end else begin
                  ch_in    = '0;
                  state_in = ST_MEAN_GO;
               end
            end
         end
         ST_MEAN_GO: begin
            mean_in[ch_ff] = mean_new;
            state_in       = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: begin
            state_in = ST_NEXT;
            priority if (hi <= lo) begin
               level_in[ch_ff] = (mean_ff[ch_ff] > lo) ? FULL_LEVEL : '0;
            end else if (mean_ff[ch_ff] <= lo) begin
               level_in[ch_ff] = '0;
            end else if (mean_ff[ch_ff] >= hi) begin
               level_in[ch_ff] = FULL_LEVEL;
            end else begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            prod_in  = scale_prod;
            state_in = ST_LEVEL_GO;
         end
         ST_LEVEL_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = prod_ff;
            div_req.divisor  = hi - lo;
            state_in         = ST_LEVEL_WAIT;
         end
         ST_LEVEL_WAIT: begin
            if (div_rsp.done) begin
               level_in[ch_ff] = div_rsp.quotient[LEVEL_W-1:0];
               state_in        = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (ch_ff == CH_LAST) begin
               state_in = ST_FINISH;
            end else begin
               ch_in    = ch_ff + 1'b1;
               state_in = ST_MEAN_GO;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               for (int c = 0; c < NCH; c++) begin
                  lvl_out_in[c]  = lvl_ovr[c];
                  filt_out_in[c] = mean_ff[c];
                  sum_in[c]      = '0;
                  peak_in[c]     = '0;
                  floor_in[c]    = SAMPLE_MAX;
               end
               round_in     = '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= '0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NCH; c++) begin
            sum_ff[c]   <= '0;
            peak_ff[c]  <= '0;
            floor_ff[c] <= SAMPLE_MAX;
         end
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int c = 0; c < NCH; c++) begin
            sum_ff[c]   <= sum_in[c];
            peak_ff[c]  <= peak_in[c];
            floor_ff[c] <= floor_in[c];
         end
      end
      mode_ff <= mode_in;
      prod_ff <= prod_in;
      for (int c = 0; c < NCH; c++) begin
         mean_ff[c]     <= mean_in[c];
         level_ff[c]    <= level_in[c];
         lvl_out_ff[c]  <= lvl_out_in[c];
         filt_out_ff[c] <= filt_out_in[c];
      end
   end

   assign req_ch.ready = (state_ff == ST_IDLE);

   assign rsp_ch.valid                = rsp_valid_ff;
   assign rsp_ch.level_lower_left     = lvl_out_ff[0];
   assign rsp_ch.level_lower_right    = lvl_out_ff[1];
   assign rsp_ch.level_upper_left     = lvl_out_ff[2];
   assign rsp_ch.level_upper_right    = lvl_out_ff[3];
   assign rsp_ch.filtered_lower_left  = filt_out_ff[0];
   assign rsp_ch.filtered_lower_right = filt_out_ff[1];
   assign rsp_ch.filtered_upper_left  = filt_out_ff[2];
   assign rsp_ch.filtered_upper_right = filt_out_ff[3];

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      round_ff <= ROUND_LAST)
      else $error("round counter out of window");

   a_beat_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result beat not produced by window finish");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> lvl_out_ff[0] <= FULL_LEVEL && lvl_out_ff[1] <= FULL_LEVEL &&
                       lvl_out_ff[2] <= FULL_LEVEL && lvl_out_ff[3] <= FULL_LEVEL)
      else $error("level beyond full scale");

endmodule

// ----- verif/trimmed_mean_sensor_normalizer_top_test.sv -----
// Testbench: randomized rounds against a scoreboard of trimmed means and normalized levels.
`timescale 1ns / 100ps

module trimmed_mean_sensor_normalizer_top_test
   import tmsn_pkg::*;
();

   localparam int unsigned HOLD_CYCLES  = 1500;
   localparam int unsigned DRAIN_CYCLES = 300;
   localparam int unsigned STALL_LIMIT  = 10000;

   localparam logic [MODE_W-1:0] STEER_NONE = '0;

   typedef enum int unsigned {
      CAL_MAX_LL, CAL_MAX_LR, CAL_MAX_UL, CAL_MAX_UR,
      CAL_MIN_LL, CAL_MIN_LR, CAL_MIN_UL, CAL_MIN_UR
   } cal_index_type;

   typedef enum int unsigned {
      SPAN_FULL, SPAN_INVERTED, SPAN_FLAT, SPAN_TYPICAL, SPAN_WILD
   } span_kind_type;

   typedef struct packed {
      logic [NCH-1:0][SAMPLE_W-1:0] sample;
      logic [MODE_W-1:0]            mode;
   } round_type;

   typedef struct packed {
      logic [NCH-1:0][LEVEL_W-1:0]  level;
      logic [NCH-1:0][SAMPLE_W-1:0] filtered;
   } level_beat_type;

   logic clock = 1'b0;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata;
   logic [CSR_DW-1:0] prdata;
   logic pready;

   tmsn_req_if req_bus ();
   tmsn_rsp_if rsp_bus ();

   trimmed_mean_sensor_normalizer_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_bus),
      .rsp_ch  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   round_type      pending_rounds [$];
   level_beat_type expected_levels [$];

   logic [SAMPLE_W-1:0] cal_max [NCH];
   logic [SAMPLE_W-1:0] cal_min [NCH];
   int unsigned         win_round;
   logic [SUM_W-1:0]    win_sum [NCH];
   logic [SAMPLE_W-1:0] win_peak [NCH];
   logic [SAMPLE_W-1:0] win_floor [NCH];

   string chan_name [NCH] = '{"lower left", "lower right", "upper left", "upper right"};

   bit          req_took;
   bit          rsp_took;
   bit          calm;
   bit          long_hold_go;
   bit          long_hold_done;
   int unsigned hold_count;
   int unsigned send_idle;
   int unsigned send_quiet;
   int unsigned take_idle;
   int unsigned take_quiet;
   int unsigned stall_cycles;
   int unsigned err_count;
   int unsigned rounds_taken;
   int unsigned windows_checked;
   int unsigned cal_sets;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [LEVEL_W-1:0] scale_level(input int unsigned mean,
                                                      input int unsigned hi,
                                                      input int unsigned lo);
      if (hi <= lo) return (mean > lo) ? FULL_LEVEL : LEVEL_W'(0);
      if (mean <= lo) return LEVEL_W'(0);
      if (mean >= hi) return FULL_LEVEL;
      return LEVEL_W'((mean - lo) * FULL_LEVEL / (hi - lo));
   endfunction

   task automatic clear_window();
      int c;
      win_round = 0;
      for (c = 0; c < NCH; c++) begin
         win_sum[c]   = '0;
         win_peak[c]  = '0;
         win_floor[c] = SAMPLE_MAX;
      end
   endtask

   // accumulate one round; the closing round of a window yields one expected beat
   task automatic absorb_round(input round_type r);
      level_beat_type beat;
      int unsigned trim;
      int unsigned mean;
      int c;
      for (c = 0; c < NCH; c++) begin
         win_sum[c] = win_sum[c] + r.sample[c];
         if (r.sample[c] > win_peak[c]) win_peak[c] = r.sample[c];
         if (r.sample[c] < win_floor[c]) win_floor[c] = r.sample[c];
      end
      if (win_round < WINDOW - 1) begin
         win_round++;
      end else begin
         for (c = 0; c < NCH; c++) begin
            trim = win_peak[c] + win_floor[c];
            mean = (win_sum[c] > trim) ? (win_sum[c] - trim) / (WINDOW - 2) : 0;
            if (mean > SAMPLE_MAX) mean = SAMPLE_MAX;
            beat.filtered[c] = SAMPLE_W'(mean);
            beat.level[c]    = scale_level(mean, cal_max[c], cal_min[c]);
         end
         case (r.mode)
            STEER_HIGH_LOW: begin
               beat.level[2] = LEVEL_HIGH;
               beat.level[3] = LEVEL_LOW;
            end
            STEER_LOW_HIGH: begin
               beat.level[2] = LEVEL_LOW;
               beat.level[3] = LEVEL_HIGH;
            end
            STEER_COPY_LOWER: begin
               beat.level[2] = beat.level[0];
               beat.level[3] = beat.level[1];
            end
            STEER_LEFT_RIGHT: begin
               beat.level[2] = beat.level[3];
            end
            default: begin
            end
         endcase
         expected_levels.push_back(beat);
         clear_window();
      end
   endtask

   task automatic write_cal(input int unsigned idx, input logic [SAMPLE_W-1:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = CSR_AW'(idx << 2);
      pwdata  = CSR_DW'(value);
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      if (idx < NCH) cal_max[idx] = value;
      else cal_min[idx - NCH] = value;
   endtask

   task automatic set_calibration(input span_kind_type kind);
      int unsigned hi;
      int unsigned lo;
      int c;
      for (c = 0; c < NCH; c++) begin
         case (kind)
            SPAN_FULL: begin
               hi = SAMPLE_MAX;
               lo = 0;
            end
            SPAN_INVERTED: begin
               lo = (c == 0) ? SAMPLE_MAX : $urandom_range(1, SAMPLE_MAX);
               hi = (c == 0) ? 0 : $urandom_range(0, lo - 1);
            end
            SPAN_FLAT: begin
               lo = (c == 3) ? 0 : (c == 2) ? SAMPLE_MAX : $urandom_range(0, SAMPLE_MAX);
               hi = lo;
            end
            SPAN_TYPICAL: begin
               lo = $urandom_range(0, 1500);
               hi = $urandom_range(2500, SAMPLE_MAX);
            end
            default: begin
               lo = $urandom_range(0, SAMPLE_MAX);
               hi = $urandom_range(0, SAMPLE_MAX);
            end
         endcase
         write_cal(CAL_MAX_LL + c, SAMPLE_W'(hi));
         write_cal(CAL_MIN_LL + c, SAMPLE_W'(lo));
      end
      cal_sets++;
   endtask

   // windows of rounds clustered per channel, with outliers and exact span edges
   task automatic queue_windows(input int unsigned count);
      round_type item;
      int centre [NCH];
      int spread [NCH];
      int w;
      int r;
      int c;
      int v;
      for (w = 0; w < count; w++) begin
         for (c = 0; c < NCH; c++) begin
            centre[c] = $urandom_range(0, SAMPLE_MAX);
            case ($urandom_range(0, 7))
               0: begin
                  centre[c] = cal_min[c];
                  spread[c] = 0;
               end
               1: begin
                  centre[c] = cal_max[c];
                  spread[c] = 0;
               end
               2: spread[c] = SAMPLE_MAX;
               3, 4: spread[c] = 255;
               default: spread[c] = 15;
            endcase
         end
         for (r = 0; r < WINDOW; r++) begin
            for (c = 0; c < NCH; c++) begin
               v = centre[c] + int'($urandom_range(0, 2 * spread[c])) - spread[c];
               if (v < 0) v = 0;
               if (v > SAMPLE_MAX) v = SAMPLE_MAX;
               if ($urandom_range(0, 19) == 0) v = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
               item.sample[c] = SAMPLE_W'(v);
            end
            item.mode = MODE_W'($urandom_range(0, 7));
            pending_rounds.push_back(item);
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_rounds.size() != 0 || expected_levels.size() != 0) @(posedge clock);
   endtask

   task automatic settle();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(negedge clock) begin : round_sender
      int unsigned roll;
      logic go;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!(req_bus.valid && !req_took)) begin
         if (req_took) void'(pending_rounds.pop_front());
         go = 1'b1;
         if (calm) begin
            go = 1'b1;
         end else if (send_idle > 0) begin
            send_idle--;
            go = 1'b0;
         end else if (send_quiet > 0) begin
            send_quiet--;
         end else begin
            roll = $urandom_range(0, 15);
            if (roll < 2) begin
               send_idle = $urandom_range(0, 13);
               go = 1'b0;
            end else if (roll == 2) begin
               send_quiet = $urandom_range(20, 80);
            end
         end
         if (go && pending_rounds.size() != 0) begin
            req_bus.valid              <= 1'b1;
            req_bus.sample_lower_left  <= pending_rounds[0].sample[0];
            req_bus.sample_lower_right <= pending_rounds[0].sample[1];
            req_bus.sample_upper_left  <= pending_rounds[0].sample[2];
            req_bus.sample_upper_right <= pending_rounds[0].sample[3];
            req_bus.steer_mode         <= pending_rounds[0].mode;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : level_taker
      int unsigned roll;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (long_hold_go && !long_hold_done) begin
         rsp_bus.ready <= 1'b0;
         hold_count++;
         if (hold_count >= HOLD_CYCLES) long_hold_done = 1'b1;
      end else if (calm) begin
         rsp_bus.ready <= 1'b1;
      end else if (take_idle > 0) begin
         take_idle--;
         rsp_bus.ready <= 1'b0;
      end else if (take_quiet > 0) begin
         take_quiet--;
         rsp_bus.ready <= 1'b1;
      end else begin
         roll = $urandom_range(0, 15);
         if (roll < 2) begin
            take_idle = $urandom_range(0, 13);
            rsp_bus.ready <= 1'b0;
         end else begin
            if (roll == 2) take_quiet = $urandom_range(20, 80);
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : beat_monitor
      round_type      seen;
      level_beat_type got;
      level_beat_type want;
      int c;
      req_took = 1'b0;
      rsp_took = 1'b0;
      if (!reset) begin
         req_took = req_bus.valid && req_bus.ready;
         rsp_took = rsp_bus.valid && rsp_bus.ready;
         if (req_took) begin
            seen.sample[0] = req_bus.sample_lower_left;
            seen.sample[1] = req_bus.sample_lower_right;
            seen.sample[2] = req_bus.sample_upper_left;
            seen.sample[3] = req_bus.sample_upper_right;
            seen.mode      = req_bus.steer_mode;
            rounds_taken++;
            absorb_round(seen);
         end
         if (rsp_took) begin
            got.level[0]    = rsp_bus.level_lower_left;
            got.level[1]    = rsp_bus.level_lower_right;
            got.level[2]    = rsp_bus.level_upper_left;
            got.level[3]    = rsp_bus.level_upper_right;
            got.filtered[0] = rsp_bus.filtered_lower_left;
            got.filtered[1] = rsp_bus.filtered_lower_right;
            got.filtered[2] = rsp_bus.filtered_upper_left;
            got.filtered[3] = rsp_bus.filtered_upper_right;
            if (expected_levels.size() == 0) begin
               $display("%0t: unexpected result beat, levels %h filtered %h",
                        $time, got.level, got.filtered);
               err_count++;
            end else begin
               want = expected_levels.pop_front();
               windows_checked++;
               for (c = 0; c < NCH; c++) begin
                  if (got.level[c] !== want.level[c]) begin
                     $display("%0t: %s level expected %0d, got %0d",
                              $time, chan_name[c], want.level[c], got.level[c]);
                     err_count++;
                  end
                  if (got.filtered[c] !== want.filtered[c]) begin
                     $display("%0t: %s filtered expected %0d, got %0d",
                              $time, chan_name[c], want.filtered[c], got.filtered[c]);
                     err_count++;
                  end
               end
            end
         end
         if (req_took || rsp_took) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, stall_cycles);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin : run_plan
      round_type item;
      int w;
      int r;
      int c;
      reset   = 1'b1;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      req_bus.valid              = 1'b0;
      req_bus.sample_lower_left  = '0;
      req_bus.sample_lower_right = '0;
      req_bus.sample_upper_left  = '0;
      req_bus.sample_upper_right = '0;
      req_bus.steer_mode         = '0;
      rsp_bus.ready              = 1'b0;
      for (c = 0; c < NCH; c++) begin
         cal_max[c] = MAX_RESET;
         cal_min[c] = MIN_RESET;
      end
      clear_window();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed windows: zeros, full scale, alternating extremes, ramps, random
      for (w = 0; w < 5; w++) begin
         for (r = 0; r < WINDOW; r++) begin
            for (c = 0; c < NCH; c++) begin
               case (w)
                  0: item.sample[c] = '0;
                  1: item.sample[c] = SAMPLE_MAX;
                  2: item.sample[c] = ((r + c) % 2) ? SAMPLE_MAX : '0;
                  3: item.sample[c] = SAMPLE_W'(r * 900 + c * 37);
                  default: item.sample[c] = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
               endcase
            end
            item.mode = MODE_W'($urandom_range(0, 7));
            if (r == WINDOW - 1) begin
               case (w)
                  0: item.mode = STEER_NONE;
                  1: item.mode = STEER_HIGH_LOW;
                  2: item.mode = STEER_LOW_HIGH;
                  3: item.mode = STEER_COPY_LOWER;
                  default: item.mode = STEER_LEFT_RIGHT;
               endcase
            end
            pending_rounds.push_back(item);
         end
      end
      settle();

      set_calibration(SPAN_FULL);
      queue_windows(30);
      settle();

      set_calibration(SPAN_INVERTED);
      queue_windows(20);
      settle();

      set_calibration(SPAN_FLAT);
      queue_windows(20);
      settle();

      // results held back long enough for the input side to back up
      set_calibration(SPAN_TYPICAL);
      queue_windows(25);
      long_hold_go = 1'b1;
      wait_drained();
      queue_windows(25);
      settle();

      set_calibration(SPAN_WILD);
      calm = 1'b1;
      queue_windows(65);
      settle();

      $display("Run covered %0d rounds, %0d windows compared, %0d calibration sets",
               rounds_taken, windows_checked, cal_sets);
      $display("incl. full, inverted, flat and random spans, all steering codes, long stall");
      if (err_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", err_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
